FILE: rtl/fes_pkg.sv
`timescale 1ns / 1ps

package fes_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] BUDGET_RESET = 8'd3;
  localparam logic [7:0] COUNT_MAX    = 8'd255;
  localparam logic [2:0] CAUSE_DEVICE_LOST = 3'd1;
  localparam logic [2:0] CAUSE_NONE        = 3'd0;

  typedef enum logic [2:0] {
    ACT_FAULT    = 3'd0,
    ACT_TERMINAL = 3'd1,
    ACT_SUCCESS  = 3'd2,
    ACT_RETRY    = 3'd3,
    ACT_STOP     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    FK_PRESSURE = 2'd0,
    FK_INTERNAL = 2'd1,
    FK_DEV_LOST = 2'd2
  } fault_kind_t;

  localparam logic [2:0] TERM_RUNNING = 3'd0;

  typedef enum logic [1:0] {
    MODE_HEALTHY   = 2'd0,
    MODE_PRESSURE  = 2'd1,
    MODE_SUSPENDED = 2'd2,
    MODE_DEAD      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_PRESSURE,
    EV_INTERNAL,
    EV_DEV_LOST,
    EV_TERMINAL,
    EV_SUCCESS,
    EV_RETRY,
    EV_STOP
  } ev_kind_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_BUDGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_BUDGET = 1'd1;

  typedef struct packed {
    ev_kind_t   kind;
    logic [2:0] cause;
  } fes_event_t;

  typedef struct packed {
    logic       run_reclaim;
    logic       pressure_notice;
    logic       pressure_suspend_notice;
    logic       internal_suspend_notice;
    logic       dead_notice;
    logic [2:0] cause_out;
    mode_t      mode_out;
  } fes_result_t;

endpackage

FILE: rtl/fes_front.sv
`timescale 1ns / 1ps

module fes_front import fes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  push,
  output fes_event_t            push_ev,
  input  logic                  q_full
);

  logic       fv_r;
  fes_event_t ev_r;
  fes_event_t ev_nxt;
  logic [2:0] act;
  logic [1:0] kind;
  logic [2:0] code;

  assign act  = in_tdata[2:0];
  assign kind = in_tdata[4:3];
  assign code = in_tdata[7:5];

  always_comb begin
    ev_nxt.kind  = EV_NONE;
    ev_nxt.cause = CAUSE_NONE;
    unique case (act)
      ACT_FAULT: begin
        unique case (kind)
          FK_PRESSURE: ev_nxt.kind = EV_PRESSURE;
          FK_DEV_LOST: begin
            ev_nxt.kind  = EV_DEV_LOST;
            ev_nxt.cause = CAUSE_DEVICE_LOST;
          end
          // The unused kind is treated like an internal fault.
          default:     ev_nxt.kind = EV_INTERNAL;
        endcase
      end
      ACT_TERMINAL: begin
        if (code != TERM_RUNNING) begin
          ev_nxt.kind  = EV_TERMINAL;
          ev_nxt.cause = code;
        end
      end
      ACT_SUCCESS: ev_nxt.kind = EV_SUCCESS;
      ACT_RETRY:   ev_nxt.kind = EV_RETRY;
      ACT_STOP:    ev_nxt.kind = EV_STOP;
      default:     ev_nxt.kind = EV_NONE;
    endcase
  end

  assign push      = fv_r && !q_full;
  assign push_ev   = ev_r;
  assign in_tready = !fv_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tready) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

FILE: rtl/fes_queue.sv
`timescale 1ns / 1ps

module fes_queue import fes_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fes_event_t push_ev,
  output logic       full,
  input  logic       pop,
  output fes_event_t head_ev,
  output logic       empty
);

  fes_event_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head_ev = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ev;
    end
  end

endmodule

FILE: rtl/fes_back.sv
`timescale 1ns / 1ps

module fes_back import fes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   q_empty,
  input  fes_event_t             head_ev,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [7:0]  p_budget_r;
  logic [7:0]  i_budget_r;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  p_cnt_r, p_cnt_nxt;
  logic [7:0]  i_cnt_r, i_cnt_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic        dead_arm_r, dead_arm_nxt;
  logic        susp_arm_r, susp_arm_nxt;
  logic        stopped_r, stopped_nxt;
  logic        ov_r;
  fes_result_t res_r, res_nxt;
  logic [7:0]  p_inc;
  logic [7:0]  i_inc;

  assign pop        = !q_empty && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, res_r.mode_out, res_r.cause_out, res_r.dead_notice,
                       res_r.internal_suspend_notice, res_r.pressure_suspend_notice,
                       res_r.pressure_notice, res_r.run_reclaim};

  assign p_inc = (p_cnt_r == COUNT_MAX) ? p_cnt_r : p_cnt_r + 8'd1;
  assign i_inc = (i_cnt_r == COUNT_MAX) ? i_cnt_r : i_cnt_r + 8'd1;

  always_comb begin
    mode_nxt     = mode_r;
    p_cnt_nxt    = p_cnt_r;
    i_cnt_nxt    = i_cnt_r;
    cause_nxt    = cause_r;
    dead_arm_nxt = dead_arm_r;
    susp_arm_nxt = susp_arm_r;
    stopped_nxt  = stopped_r;
    res_nxt      = '0;
    unique case (head_ev.kind)
      EV_DEV_LOST, EV_TERMINAL: begin
        if (mode_r != MODE_DEAD) begin
          mode_nxt          = MODE_DEAD;
          cause_nxt         = head_ev.cause;
          res_nxt.cause_out = head_ev.cause;
          res_nxt.dead_notice = dead_arm_r;
          dead_arm_nxt      = 1'b0;
        end
      end
      EV_PRESSURE: begin
        if (mode_r != MODE_DEAD && mode_r != MODE_SUSPENDED) begin
          p_cnt_nxt = p_inc;
          if (p_inc <= p_budget_r) begin
            res_nxt.run_reclaim     = 1'b1;
            res_nxt.pressure_notice = (p_inc == 8'd1);
            mode_nxt                = MODE_PRESSURE;
          end else begin
            res_nxt.pressure_suspend_notice = susp_arm_r;
            susp_arm_nxt                    = 1'b0;
            mode_nxt                        = MODE_SUSPENDED;
          end
        end
      end
      EV_INTERNAL: begin
        if (mode_r != MODE_DEAD && mode_r != MODE_SUSPENDED) begin
          i_cnt_nxt = i_inc;
          if (i_inc >= i_budget_r) begin
            res_nxt.internal_suspend_notice = susp_arm_r;
            susp_arm_nxt                    = 1'b0;
            mode_nxt                        = MODE_SUSPENDED;
          end
        end
      end
      EV_SUCCESS: begin
        if (mode_r == MODE_HEALTHY || mode_r == MODE_PRESSURE) begin
          p_cnt_nxt = '0;
          i_cnt_nxt = '0;
          mode_nxt  = MODE_HEALTHY;
        end
      end
      EV_RETRY: begin
        if (mode_r == MODE_SUSPENDED && !stopped_r) begin
          p_cnt_nxt    = '0;
          i_cnt_nxt    = '0;
          mode_nxt     = MODE_HEALTHY;
          susp_arm_nxt = 1'b1;
        end
      end
      EV_STOP: begin
        if (mode_r == MODE_SUSPENDED) begin
          stopped_nxt  = 1'b1;
          susp_arm_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    res_nxt.mode_out = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_budget_r <= BUDGET_RESET;
      i_budget_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESSURE_BUDGET: p_budget_r <= cfg_wdata;
        CFG_INTERNAL_BUDGET: i_budget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HEALTHY;
      p_cnt_r    <= '0;
      i_cnt_r    <= '0;
      cause_r    <= CAUSE_NONE;
      dead_arm_r <= 1'b1;
      susp_arm_r <= 1'b1;
      stopped_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (pop) begin
        mode_r     <= mode_nxt;
        p_cnt_r    <= p_cnt_nxt;
        i_cnt_r    <= i_cnt_nxt;
        cause_r    <= cause_nxt;
        dead_arm_r <= dead_arm_nxt;
        susp_arm_r <= susp_arm_nxt;
        stopped_r  <= stopped_nxt;
      end
      if (pop) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/fault_escalation_supervisor.sv
`timescale 1ns / 1ps

// Fault escalation supervisor: tracks a worker's health from a stream of
// events and answers each event with exactly one result beat.
// Input channel in_*: one event per beat (action, fault kind, terminal code).
// Result channel out_*: effect flags, dead cause and the mode after the event.
// Configuration port cfg_*: index 0 sets the pressure retry budget, index 1
// the internal retry budget; write only while no events are in flight.
// An accepted event passes a classify register, a four-entry queue and the
// state update, whose registered result drives out_tvalid and out_tdata.
// One event is accepted per cycle while the queue is not full; each
// event depends on the previous one only via compare and increment logic.
// Synchronous active-low reset returns the mode to healthy, clears both
// counters and the stored cause, arms both one-shot notices, clears the
// stopped flag, reloads both budgets to 3 and empties all pipeline state.
// When the receiver holds out_tready low the result register keeps its beat,
// the queue absorbs up to four more events plus one in the classify stage,
// and in_tready then drops until space frees up.

module fault_escalation_supervisor import fes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] action, [4:3] fault_kind, [7:5] terminal_code
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] run_reclaim, [1] pressure_notice, [2] pressure_suspend_notice,
  // [3] internal_suspend_notice, [4] dead_notice, [7:5] cause_out,
  // [9:8] mode_out, [15:10] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]             cfg_wdata
);

  logic       push;
  fes_event_t push_ev;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  fes_event_t head_ev;

  fes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_ev   (push_ev),
    .q_full    (q_full)
  );

  fes_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .full    (q_full),
    .pop     (pop),
    .head_ev (head_ev),
    .empty   (q_empty)
  );

  fes_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .head_ev    (head_ev),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
